// ===== sv/aidpp_pkg.sv =====
// ----------------------------------------------------------------------------
// aidpp_pkg: shared types and codes for the ordered array store
// Commands, status codes and the per-cell control struct.
// ----------------------------------------------------------------------------
package aidpp_pkg;

   localparam int ELEM_W = 32;

   typedef enum logic [1:0] {
      CMD_INSERT = 2'd0,
      CMD_SORTED = 2'd1,
      CMD_DELETE = 2'd2,
      CMD_PURGE  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_DONE   = 2'd0,
      ST_BADPOS = 2'd1,
      ST_FULL   = 2'd2,
      ST_RSVD   = 2'd3
   } status_type;

   // per-cycle command broadcast to every cell
   typedef struct packed {
      logic             ins_en;   // open a slot at ins_pos, shift up above it
      logic             del_en;   // close slot at del_pos, shift down above it
      logic             rot_en;   // rotate row down by one (readout / scan)
      logic [6:0]       ins_pos;
      logic [6:0]       del_pos;
      logic [ELEM_W-1:0] value;
   } cell_ctl_type;

endpackage

// ===== sv/aidpp_cell.sv =====
// ----------------------------------------------------------------------------
// aidpp_cell: one array slot
// Holds one element; takes from its lower or upper neighbor on a shift.
// ----------------------------------------------------------------------------
module aidpp_cell #(
   parameter logic [6:0] POS = 7'd0
) (
   input  logic                       clock,
   input  aidpp_pkg::cell_ctl_type    ctl,
   input  logic [aidpp_pkg::ELEM_W-1:0] below,
   input  logic [aidpp_pkg::ELEM_W-1:0] above,
   input  logic [aidpp_pkg::ELEM_W-1:0] wrap,
   input  logic                       top,
   output logic [aidpp_pkg::ELEM_W-1:0] data
);
   logic [aidpp_pkg::ELEM_W-1:0] data_ff, data_in;

   always_comb begin
      data_in = data_ff;
      if (ctl.ins_en) begin
         if (POS == ctl.ins_pos)     data_in = ctl.value;
         else if (POS > ctl.ins_pos) data_in = below;
      end else if (ctl.del_en) begin
         if (POS >= ctl.del_pos)     data_in = above;
      end else if (ctl.rot_en) begin
         data_in = top ? wrap : above;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;
endmodule

// ===== sv/aidpp_prime.sv =====
// ----------------------------------------------------------------------------
// aidpp_prime: iterative trial-division prime test
// One divisor step per remainder pass; remainder by restoring division.
// ----------------------------------------------------------------------------
module aidpp_prime (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] value,
   output logic        done,
   output logic        prime
);
   logic [31:0] v_ff, v_in;
   logic [31:0] d_ff, d_in;
   logic [31:0] r_ff, r_in;
   logic [5:0]  b_ff, b_in;
   logic        busy_ff, busy_in, div_ff, div_in;
   logic        done_ff, done_in, prime_ff, prime_in;
   logic [63:0] sq;
   logic [32:0] rs;

   assign sq = {32'd0, d_ff} * {32'd0, d_ff};
   assign rs = {r_ff, v_ff[b_ff[4:0]]};

   always_comb begin
      v_in = v_ff; d_in = d_ff; r_in = r_ff; b_in = b_ff;
      busy_in = busy_ff; div_in = div_ff; done_in = 1'b0; prime_in = prime_ff;
      if (start) begin
         v_in = value; d_in = 32'd2; busy_in = 1'b1; div_in = 1'b0;
         if (value[31] || value < 32'd2) begin
            busy_in = 1'b0; done_in = 1'b1; prime_in = 1'b0;
         end
      end else if (busy_ff && !div_ff) begin
         if (sq > {32'd0, v_ff}) begin
            busy_in = 1'b0; done_in = 1'b1; prime_in = 1'b1;
         end else begin
            div_in = 1'b1; r_in = 32'd0; b_in = 6'd31;
         end
      end else if (busy_ff) begin
         r_in = (rs >= {1'b0, d_ff}) ? 32'(rs - {1'b0, d_ff}) : rs[31:0];
         b_in = b_ff - 6'd1;
         if (b_ff == 6'd0) begin
            div_in = 1'b0;
            if (r_in == 32'd0) begin
               busy_in = 1'b0; done_in = 1'b1; prime_in = 1'b0;
            end else begin
               d_in = d_ff + 32'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; div_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in; div_ff <= div_in; done_ff <= done_in;
      end
      v_ff <= v_in; d_ff <= d_in; r_ff <= r_in; b_ff <= b_in; prime_ff <= prime_in;
   end

   assign done  = done_ff;
   assign prime = prime_ff;
endmodule

// ===== sv/array_insert_delete_prime_purge.sv =====
// Ordered array store. One request per command; results stream one per cycle while rsp_tready is held high.
// Insert/delete/sorted insert: then report each element of the row (<= CAPACITY), or one empty result.
// Sorted insert first scans the whole row by rotation.
// Purge: trial-division test of each stored element; primes are deleted, others rotated and kept.
// Sequential: one request at a time. Synchronous reset empties the array.
// ----------------------------------------------------------------------------
// array_insert_delete_prime_purge: command sequencer over a row of cells
// Row of CAPACITY cells shifted by broadcast controls; readout by rotation.
// ----------------------------------------------------------------------------
module array_insert_delete_prime_purge #(
   parameter int CAPACITY = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // cmd[1:0], value[33:2], position[40:34], zero pad
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // status[1:0], element[33:2], index[39:34]
   output logic        rsp_tuser,   // empty_res
   output logic        rsp_tlast    // last
);
   localparam int W = aidpp_pkg::ELEM_W;

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_EXEC  = 6'b000010,
      S_SCAN  = 6'b000100,
      S_PWAIT = 6'b001000,
      S_OUT   = 6'b010000,
      S_HOLD  = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   aidpp_pkg::cell_ctl_type ctl;
   logic [W-1:0] cell_q [CAPACITY];
   logic [6:0] count_ff, count_in, cnt_ff, cnt_in, ipos_ff, ipos_in;
   logic [6:0] kept_ff, kept_in;
   logic [1:0] cmd_ff, cmd_in;
   logic [W-1:0] val_ff, val_in;
   logic [6:0] pos_ff, pos_in;
   aidpp_pkg::status_type st_ff, st_in;
   aidpp_pkg::status_type os_ff, os_in;
   logic ov_ff, ov_in, ol_ff, ol_in, oe_ff, oe_in;
   logic [5:0] oi_ff, oi_in;
   logic [W-1:0] od_ff, od_in;
   logic pstart, pdone, pprime;
   logic [6:0] cap7;

   assign cap7 = 7'(CAPACITY);

   for (genvar g = 0; g < CAPACITY; g++) begin : g_row
      aidpp_cell #(.POS(7'(g))) u_cell (
         .clock(clock), .ctl(ctl),
         .below(cell_q[(g == 0) ? 0 : g - 1]),
         .above(cell_q[(g == CAPACITY - 1) ? g : g + 1]),
         .wrap(cell_q[0]),
         .top(7'(g) == count_ff - 7'd1),
         .data(cell_q[g])
      );
   end

   aidpp_prime u_prime (
      .clock(clock), .reset(reset), .start(pstart), .value(cell_q[0]),
      .done(pdone), .prime(pprime)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = ov_ff;
   assign rsp_tdata  = {oi_ff, od_ff, os_ff};
   assign rsp_tuser  = oe_ff;
   assign rsp_tlast  = ol_ff;

   always_comb begin
      state_in = state_ff; count_in = count_ff; cnt_in = cnt_ff; ipos_in = ipos_ff;
      kept_in = kept_ff; cmd_in = cmd_ff; val_in = val_ff; pos_in = pos_ff; st_in = st_ff;
      ov_in = ov_ff; ol_in = ol_ff; oe_in = oe_ff; oi_in = oi_ff; od_in = od_ff;
      os_in = os_ff;
      ctl = '0; ctl.value = val_ff; pstart = 1'b0;
      if (ov_ff && rsp_tready) ov_in = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd_in = req_tdata[1:0]; val_in = req_tdata[33:2]; pos_in = req_tdata[40:34];
               cnt_in = 7'd0; ipos_in = 7'd0; kept_in = 7'd0;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            st_in = aidpp_pkg::ST_DONE;
            state_in = S_OUT;
            case (cmd_ff)
               aidpp_pkg::CMD_INSERT: begin
                  if (pos_ff > count_ff) st_in = aidpp_pkg::ST_BADPOS;
                  else if (count_ff >= cap7) st_in = aidpp_pkg::ST_FULL;
                  else begin
                     ctl.ins_en = 1'b1; ctl.ins_pos = pos_ff; count_in = count_ff + 7'd1;
                  end
               end
               aidpp_pkg::CMD_SORTED: begin
                  if (count_ff >= cap7) st_in = aidpp_pkg::ST_FULL;
                  else if (count_ff == 7'd0) begin
                     ctl.ins_en = 1'b1; ctl.ins_pos = 7'd0; count_in = 7'd1;
                  end else state_in = S_SCAN;
               end
               aidpp_pkg::CMD_DELETE: begin
                  if (pos_ff >= count_ff) st_in = aidpp_pkg::ST_BADPOS;
                  else begin
                     ctl.del_en = 1'b1; ctl.del_pos = pos_ff; count_in = count_ff - 7'd1;
                  end
               end
               default: begin
                  if (count_ff != 7'd0) begin
                     state_in = S_PWAIT; pstart = 1'b1;
                  end
               end
            endcase
         end
         S_SCAN: begin
            // rotate full row, insert after the last element not greater than value (signed)
            if (cnt_ff == count_ff) begin
               ctl.ins_en = 1'b1; ctl.ins_pos = ipos_ff; count_in = count_ff + 7'd1;
               cnt_in = 7'd0; state_in = S_OUT;
            end else begin
               if (!($signed(cell_q[0]) > $signed(val_ff))) ipos_in = cnt_ff + 7'd1;
               ctl.rot_en = 1'b1; cnt_in = cnt_ff + 7'd1;
            end
         end
         S_PWAIT: begin
            if (pdone) begin
               if (pprime) begin
                  ctl.del_en = 1'b1; ctl.del_pos = 7'd0; count_in = count_ff - 7'd1;
               end else begin
                  ctl.rot_en = 1'b1; kept_in = kept_ff + 7'd1;
               end
               cnt_in = cnt_ff + 7'd1;
               // done when every original element was tested
               if ((pprime ? count_ff - 7'd1 : count_ff) == kept_in) begin
                  cnt_in = 7'd0; state_in = S_OUT;
               end else state_in = S_HOLD;
            end
         end
         S_HOLD: begin
            pstart = 1'b1; state_in = S_PWAIT;
         end
         S_OUT: begin
            if (!ov_ff || rsp_tready) begin
               ov_in = 1'b1; oi_in = cnt_ff[5:0]; os_in = st_ff;
               if (count_ff == 7'd0) begin
                  oe_in = 1'b1; ol_in = 1'b1; od_in = '0; state_in = S_IDLE;
               end else begin
                  oe_in = 1'b0; od_in = cell_q[0]; ctl.rot_en = 1'b1;
                  cnt_in = cnt_ff + 7'd1;
                  ol_in = (cnt_ff + 7'd1 == count_ff);
                  if (ol_in) state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; count_ff <= 7'd0; ov_ff <= 1'b0;
      end else begin
         state_ff <= state_in; count_ff <= count_in; ov_ff <= ov_in;
      end
      cnt_ff <= cnt_in; ipos_ff <= ipos_in; kept_ff <= kept_in; cmd_ff <= cmd_in;
      val_ff <= val_in; pos_ff <= pos_in; st_ff <= st_in; ol_ff <= ol_in;
      oe_ff <= oe_in; oi_ff <= oi_in; od_ff <= od_in; os_ff <= os_in;
   end
endmodule
